[hw/rtl/auto_swell_envelope_gain_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the auto swell envelope gain block
// Shared wrappers that clock on clock and disable on reset.
// ----------------------------------------------------------------------------
`ifndef AUTO_SWELL_ENVELOPE_GAIN_MACROS_SVH
`define AUTO_SWELL_ENVELOPE_GAIN_MACROS_SVH

// plain property
`define ASG_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// same-cycle implication
`define ASG_ASSERT_IMP(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define ASG_ASSERT_NXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

[hw/rtl/asg_pkg.sv]
// ----------------------------------------------------------------------------
// asg_pkg
// Widths, fixed-point constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package asg_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 24;
   localparam int ENV_BITS       = SAMPLE_BITS - 1;
   localparam int MUL_W          = COEF_FRAC_BITS + 1;
   localparam int PROD_W         = 2 * MUL_W;
   localparam int MIX_FRAC       = 16;
   localparam int MIX_W          = MIX_FRAC + 1;
   localparam int GAIN_FRAC      = 12;
   localparam int GAIN_W         = 14;
   localparam int THR_W          = 23;
   localparam int CSR_DATA_W     = 24;
   localparam int CSR_ADDR_W     = 3;
   localparam int M2_W           = PROD_W + 1 - GAIN_FRAC;

   localparam logic [COEF_FRAC_BITS:0] ONE_Q = {1'b1, {COEF_FRAC_BITS{1'b0}}};
   localparam logic [PROD_W:0] HALF_Q = {{(PROD_W + 1 - COEF_FRAC_BITS){1'b0}},
                                         1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
   localparam logic [PROD_W:0] HALF_MIX = {{(PROD_W + 1 - MIX_FRAC){1'b0}},
                                           1'b1, {(MIX_FRAC - 1){1'b0}}};
   localparam logic [PROD_W:0] HALF_GAIN = {{(PROD_W + 1 - GAIN_FRAC){1'b0}},
                                            1'b1, {(GAIN_FRAC - 1){1'b0}}};
   localparam logic [MIX_W-1:0] MIX_FULL = {1'b1, {MIX_FRAC{1'b0}}};
   localparam logic [ENV_BITS-1:0] SMAXPOS = {ENV_BITS{1'b1}};

   localparam logic [23:0] RST_ATTACK  = 24'd16603404;
   localparam logic [23:0] RST_RELEASE = 24'd16774885;
   localparam logic [23:0] RST_RATE    = 24'd699;
   localparam logic [THR_W-1:0] RST_THR = 23'd83886;
   localparam logic [MIX_W-1:0] RST_MIX = 17'd65536;
   localparam logic [GAIN_W-1:0] RST_GAIN = 14'd4096;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ATTACK  = 3'd0,
      CSR_RELEASE = 3'd1,
      CSR_RATE    = 3'd2,
      CSR_THRESH  = 3'd3,
      CSR_MIX     = 3'd4,
      CSR_GAIN    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COEF_FRAC_BITS-1:0] attack;
      logic [COEF_FRAC_BITS-1:0] release_c;
      logic [COEF_FRAC_BITS-1:0] rate;
      logic [THR_W-1:0]          thresh;
      logic [MIX_W-1:0]          mix;
      logic [GAIN_W-1:0]         gain;
   } cfg_type;

   typedef struct packed {
      logic                          note;
      logic signed [SAMPLE_BITS-1:0] right;
      logic signed [SAMPLE_BITS-1:0] left;
   } res_type;

endpackage

[hw/rtl/auto_swell_envelope_gain.sv]
// ----------------------------------------------------------------------------
// auto_swell_envelope_gain
// Automatic volume swell: left-channel peak envelope, onset detection,
// one-pole swell gain, mix blend and output gain on a stereo stream.
// ----------------------------------------------------------------------------
// One stereo pair per transfer. A single 25x25 multiplier, registered, is
// stepped through eight products per item (envelope two, swell one, blend
// one, two per channel) by a 16-state sequencer. The next pair is accepted
// only once the sequencer is back in idle, which needs the output register
// to be drained. req_tready is high only while the sequencer is
// idle. The output register takes a result while the next pair is in work;
// if it is still full when a result is ready, the sequencer holds.
// Configuration writes land at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module auto_swell_envelope_gain
   import asg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: left_in [23:0], right_in [47:24]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,
   // rsp_tdata: left_out [23:0], right_out [47:24]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,
   // rsp_tuser: note_start [0]
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   res_type res;
   logic    res_valid, res_free;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   asg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   asg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_left   (req_tdata[SAMPLE_BITS-1:0]),
      .in_right  (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .res_free  (res_free),
      .res_valid (res_valid),
      .res       (res)
   );

   assign res_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res.right, res.left};
         rsp_user_in  = res.note;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[hw/rtl/asg_csr.sv]
// ----------------------------------------------------------------------------
// asg_csr
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module asg_csr
   import asg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ATTACK:  cfg_in.attack    = csr_wdata[COEF_FRAC_BITS-1:0];
            CSR_RELEASE: cfg_in.release_c = csr_wdata[COEF_FRAC_BITS-1:0];
            CSR_RATE:    cfg_in.rate      = csr_wdata[COEF_FRAC_BITS-1:0];
            CSR_THRESH:  cfg_in.thresh    = csr_wdata[THR_W-1:0];
            CSR_MIX:     cfg_in.mix       = csr_wdata[MIX_W-1:0];
            CSR_GAIN:    cfg_in.gain      = csr_wdata[GAIN_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack    <= RST_ATTACK;
         cfg_ff.release_c <= RST_RELEASE;
         cfg_ff.rate      <= RST_RATE;
         cfg_ff.thresh    <= RST_THR;
         cfg_ff.mix       <= RST_MIX;
         cfg_ff.gain      <= RST_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/asg_mul.sv]
// ----------------------------------------------------------------------------
// asg_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module asg_mul
   import asg_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [MUL_W-1:0]  mul_a,
   input  logic [MUL_W-1:0]  mul_b,
   output logic [PROD_W-1:0] mul_p
);

   logic [PROD_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         p_ff <= mul_a * mul_b;
      end
   end

   assign mul_p = p_ff;

endmodule

[hw/rtl/asg_seq.sv]
// ----------------------------------------------------------------------------
// asg_seq
// Sequencer and datapath: envelope, onset, swell, blend and channel scaling
// on one shared multiplier.
// ----------------------------------------------------------------------------
`include "auto_swell_envelope_gain_macros.svh"

module asg_seq
   import asg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_left,
   input  logic signed [SAMPLE_BITS-1:0] in_right,
   input  logic                          res_free,
   output logic                          res_valid,
   output res_type                       res
);

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_ENV_A = 16'h0002,
      ST_ENV_B = 16'h0004,
      ST_ENV_C = 16'h0008,
      ST_SWL_A = 16'h0010,
      ST_SWL_B = 16'h0020,
      ST_BLD_A = 16'h0040,
      ST_BLD_B = 16'h0080,
      ST_LFT_A = 16'h0100,
      ST_LFT_B = 16'h0200,
      ST_LFT_C = 16'h0400,
      ST_LFT_D = 16'h0800,
      ST_RGT_A = 16'h1000,
      ST_RGT_B = 16'h2000,
      ST_RGT_C = 16'h4000,
      ST_RGT_D = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]    mag_l_ff, mag_l_in, mag_r_ff, mag_r_in;
   logic                      neg_l_ff, neg_l_in, neg_r_ff, neg_r_in;
   logic [ENV_BITS-1:0]       peak_ff, peak_in;
   logic [COEF_FRAC_BITS-1:0] c_ff, c_in;
   logic [ENV_BITS-1:0]       env_ff, env_in;
   logic [COEF_FRAC_BITS:0]   sg_ff, sg_in;
   logic                      onset_ff, onset_in;
   logic [PROD_W:0]           acc_ff, acc_in;
   logic [COEF_FRAC_BITS:0]   blend_ff, blend_in;
   logic [SAMPLE_BITS-1:0]    m1_ff, m1_in;
   logic [SAMPLE_BITS-1:0]    lout_ff, lout_in;

   logic                      mul_load;
   logic [MUL_W-1:0]          mul_a, mul_b;
   logic [PROD_W-1:0]         mul_p;

   logic [PROD_W:0]           p_ext, p_round, p_gain, env_sum, blend_sum, dry;
   logic [PROD_W-COEF_FRAC_BITS:0] env_sh;
   logic [PROD_W+1-COEF_FRAC_BITS:0] sg_sum;
   logic [MIX_W-1:0]          mix_c;
   logic [SAMPLE_BITS-1:0]    mag_l_new, rout;
   logic                      onset;

   asg_mul u_mul (
      .clock (clock),
      .load  (mul_load),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic [M2_W-1:0] m,
                                                      input logic neg);
      logic [SAMPLE_BITS-1:0] lim;
      lim = '0;
      if (neg) begin
         if (m > M2_W'({1'b1, {ENV_BITS{1'b0}}})) begin
            lim = {1'b1, {ENV_BITS{1'b0}}};
         end else begin
            lim = m[SAMPLE_BITS-1:0];
         end
         return (~lim) + SAMPLE_BITS'(1);
      end
      if (m > M2_W'(SMAXPOS)) begin
         lim = {1'b0, SMAXPOS};
      end else begin
         lim = m[SAMPLE_BITS-1:0];
      end
      return lim;
   endfunction

   assign p_ext     = {1'b0, mul_p};
   assign p_round   = p_ext + HALF_Q;
   assign p_gain    = p_ext + HALF_GAIN;
   assign env_sum   = acc_ff + p_ext;
   assign env_sh    = env_sum[PROD_W:COEF_FRAC_BITS];
   assign sg_sum    = {3'b000, sg_ff} + {1'b0, p_round[PROD_W:COEF_FRAC_BITS]};
   assign mix_c     = (cfg.mix > MIX_FULL) ? MIX_FULL : cfg.mix;
   assign dry       = (PROD_W + 1)'({MIX_FULL - mix_c, {COEF_FRAC_BITS{1'b0}}});
   assign blend_sum = dry + p_ext + HALF_MIX;
   assign mag_l_new = in_left[SAMPLE_BITS-1] ? ((~in_left) + SAMPLE_BITS'(1)) : in_left;
   assign rout      = sat_out(p_gain[PROD_W:GAIN_FRAC], neg_r_ff);
   assign onset     = (env_ff < cfg.thresh) &&
                      ((env_sh > (PROD_W + 1 - COEF_FRAC_BITS)'(SMAXPOS)) ||
                       (env_sh[ENV_BITS-1:0] >= cfg.thresh));

   always_comb begin
      mul_load = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff) inside
         ST_ENV_A: begin
            mul_load = 1'b1;
            mul_a    = MUL_W'(peak_ff);
            mul_b    = ONE_Q - {1'b0, c_ff};
         end
         ST_ENV_B: begin
            mul_load = 1'b1;
            mul_a    = MUL_W'(env_ff);
            mul_b    = MUL_W'(c_ff);
         end
         ST_SWL_A: begin
            mul_load = 1'b1;
            mul_a    = ONE_Q - sg_ff;
            mul_b    = MUL_W'(cfg.rate);
         end
         ST_BLD_A: begin
            mul_load = 1'b1;
            mul_a    = MUL_W'(mix_c);
            mul_b    = sg_ff;
         end
         ST_LFT_A: begin
            mul_load = 1'b1;
            mul_a    = MUL_W'(mag_l_ff);
            mul_b    = blend_ff;
         end
         ST_LFT_C, ST_RGT_C: begin
            mul_load = 1'b1;
            mul_a    = MUL_W'(m1_ff);
            mul_b    = MUL_W'(cfg.gain);
         end
         ST_RGT_A: begin
            mul_load = 1'b1;
            mul_a    = MUL_W'(mag_r_ff);
            mul_b    = blend_ff;
         end
         default: begin
            mul_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      mag_l_in  = mag_l_ff;
      mag_r_in  = mag_r_ff;
      neg_l_in  = neg_l_ff;
      neg_r_in  = neg_r_ff;
      peak_in   = peak_ff;
      c_in      = c_ff;
      env_in    = env_ff;
      sg_in     = sg_ff;
      onset_in  = onset_ff;
      acc_in    = acc_ff;
      blend_in  = blend_ff;
      m1_in     = m1_ff;
      lout_in   = lout_ff;
      res_valid = 1'b0;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (in_valid) begin
               mag_l_in = mag_l_new;
               mag_r_in = in_right[SAMPLE_BITS-1] ? ((~in_right) + SAMPLE_BITS'(1)) : in_right;
               neg_l_in = in_left[SAMPLE_BITS-1];
               neg_r_in = in_right[SAMPLE_BITS-1];
               peak_in  = mag_l_new[SAMPLE_BITS-1] ? SMAXPOS : mag_l_new[ENV_BITS-1:0];
               c_in     = (peak_in > env_ff) ? cfg.attack : cfg.release_c;
               state_in = ST_ENV_A;
            end
         end
         ST_ENV_A: state_in = ST_ENV_B;
         ST_ENV_B: begin
            acc_in   = p_round;
            state_in = ST_ENV_C;
         end
         ST_ENV_C: begin
            env_in   = (env_sh > (PROD_W + 1 - COEF_FRAC_BITS)'(SMAXPOS)) ?
                       SMAXPOS : env_sh[ENV_BITS-1:0];
            onset_in = onset;
            if (onset) begin
               sg_in = '0;
            end
            state_in = ST_SWL_A;
         end
         ST_SWL_A: state_in = ST_SWL_B;
         ST_SWL_B: begin
            sg_in    = (sg_sum > (PROD_W + 2 - COEF_FRAC_BITS)'(ONE_Q)) ?
                       ONE_Q : sg_sum[COEF_FRAC_BITS:0];
            state_in = ST_BLD_A;
         end
         ST_BLD_A: state_in = ST_BLD_B;
         ST_BLD_B: begin
            blend_in = blend_sum[MIX_FRAC+COEF_FRAC_BITS:MIX_FRAC];
            state_in = ST_LFT_A;
         end
         ST_LFT_A: state_in = ST_LFT_B;
         ST_LFT_B, ST_RGT_B: begin
            m1_in    = p_round[COEF_FRAC_BITS+SAMPLE_BITS-1:COEF_FRAC_BITS];
            state_in = (state_ff == ST_LFT_B) ? ST_LFT_C : ST_RGT_C;
         end
         ST_LFT_C: state_in = ST_LFT_D;
         ST_LFT_D: begin
            lout_in  = sat_out(p_gain[PROD_W:GAIN_FRAC], neg_l_ff);
            state_in = ST_RGT_A;
         end
         ST_RGT_A: state_in = ST_RGT_B;
         ST_RGT_C: state_in = ST_RGT_D;
         ST_RGT_D: begin
            if (res_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         env_ff   <= '0;
         sg_ff    <= ONE_Q;
      end else begin
         state_ff <= state_in;
         env_ff   <= env_in;
         sg_ff    <= sg_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_l_ff <= mag_l_in;
      mag_r_ff <= mag_r_in;
      neg_l_ff <= neg_l_in;
      neg_r_ff <= neg_r_in;
      peak_ff  <= peak_in;
      c_ff     <= c_in;
      onset_ff <= onset_in;
      acc_ff   <= acc_in;
      blend_ff <= blend_in;
      m1_ff    <= m1_in;
      lout_ff  <= lout_in;
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign res.left  = lout_ff;
   assign res.right = rout;
   assign res.note  = onset_ff;

   `ASG_ASSERT(a_swell_bounded, sg_ff <= ONE_Q, "swell gain above unity")
   `ASG_ASSERT_NXT(a_onset_clears, (state_ff == ST_ENV_C) && onset, (sg_ff == '0) && onset_ff, "onset did not clear swell gain")
   `ASG_ASSERT_NXT(a_env_hold, state_ff != ST_ENV_C, $stable(env_ff), "envelope changed outside update step")
   `ASG_ASSERT_IMP(a_res_free, res_valid, res_free, "result issued into a full output slot")

endmodule

[dv/auto_swell_envelope_gain_checker.sv]
// ----------------------------------------------------------------------------
// auto_swell_envelope_gain_checker
// Watches the sample, result and register ports of the swell block, keeps its
// own envelope, onset and swell state, predicts each scaled stereo pair and
// compares every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module auto_swell_envelope_gain_checker
   import asg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [47:0]           rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned UNITY      = 64'd1 << COEF_FRAC_BITS;
   localparam longint unsigned HALF_UNIT  = UNITY >> 1;
   localparam longint unsigned FULL_SCALE = 64'd1 << SAMPLE_BITS;
   localparam longint unsigned NEG_LIMIT  = 64'd1 << (SAMPLE_BITS - 1);
   localparam longint unsigned MIX_UNITY  = 64'd1 << MIX_FRAC;

   cfg_type                 cfg;
   logic [ENV_BITS-1:0]     env_lvl;
   logic [ENV_BITS-1:0]     env_prev;
   logic [COEF_FRAC_BITS:0] swell;
   res_type                 expected_q[$];
   res_type                 want;

   function automatic logic [SAMPLE_BITS-1:0] scale_channel(logic [SAMPLE_BITS-1:0] x,
                                                            longint unsigned blend);
      logic            neg;
      longint unsigned mag;
      longint unsigned m1;
      longint unsigned m2;
      neg = x[SAMPLE_BITS-1];
      mag = neg ? FULL_SCALE - x : x;
      m1 = (mag * blend + HALF_UNIT) >> COEF_FRAC_BITS;
      m2 = (m1 * cfg.gain + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
      if (neg) begin
         if (m2 > NEG_LIMIT) m2 = NEG_LIMIT;
         return SAMPLE_BITS'(FULL_SCALE - m2);
      end
      if (m2 > SMAXPOS) m2 = SMAXPOS;
      return SAMPLE_BITS'(m2);
   endfunction

   function automatic res_type swell_sample(logic [SAMPLE_BITS-1:0] l_in,
                                            logic [SAMPLE_BITS-1:0] r_in);
      res_type         res;
      longint unsigned peak;
      longint unsigned coef;
      longint unsigned env_next;
      longint unsigned gain_next;
      longint unsigned mix;
      longint unsigned blend;
      logic            onset;
      peak = l_in[SAMPLE_BITS-1] ? FULL_SCALE - l_in : l_in;
      if (peak > SMAXPOS) peak = SMAXPOS;
      coef = (peak > env_lvl) ? cfg.attack : cfg.release_c;
      env_next = (peak * (UNITY - coef) + env_lvl * coef + HALF_UNIT) >> COEF_FRAC_BITS;
      if (env_next > SMAXPOS) env_next = SMAXPOS;
      env_lvl = ENV_BITS'(env_next);
      onset = (env_prev < cfg.thresh) && (env_lvl >= cfg.thresh);
      if (onset) swell = '0;
      env_prev = env_lvl;
      gain_next = swell + (((UNITY - swell) * cfg.rate + HALF_UNIT) >> COEF_FRAC_BITS);
      if (gain_next > UNITY) gain_next = UNITY;
      swell = (COEF_FRAC_BITS + 1)'(gain_next);
      mix = (cfg.mix > MIX_UNITY) ? MIX_UNITY : cfg.mix;
      blend = ((MIX_UNITY - mix) * UNITY + mix * swell + (MIX_UNITY >> 1)) >> MIX_FRAC;
      res.left  = scale_channel(l_in, blend);
      res.right = scale_channel(r_in, blend);
      res.note  = onset;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got_v,
                                  input logic [47:0] want_v);
      $display("[%0t] %s: got %h, expected %h", $realtime, what, got_v, want_v);
      mismatch_count = mismatch_count + 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.attack    = RST_ATTACK;
         cfg.release_c = RST_RELEASE;
         cfg.rate      = RST_RATE;
         cfg.thresh    = RST_THR;
         cfg.mix       = RST_MIX;
         cfg.gain      = RST_GAIN;
         env_lvl       = '0;
         env_prev      = '0;
         swell         = ONE_Q;
         expected_q.delete();
         mismatch_count = 0;
         results_outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result transfer with nothing expected",
                               rsp_tdata, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[SAMPLE_BITS-1:0] !== want.left)
                  report_mismatch("left_out", 48'(rsp_tdata[SAMPLE_BITS-1:0]),
                                  48'(unsigned'(want.left)));
               if (rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.right)
                  report_mismatch("right_out", 48'(rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
                                  48'(unsigned'(want.right)));
               if (rsp_tuser !== want.note)
                  report_mismatch("note_start", 48'(rsp_tuser), 48'(want.note));
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_ATTACK:  cfg.attack    = csr_wdata;
               CSR_RELEASE: cfg.release_c = csr_wdata;
               CSR_RATE:    cfg.rate      = csr_wdata;
               CSR_THRESH:  cfg.thresh    = csr_wdata[THR_W-1:0];
               CSR_MIX:     cfg.mix       = csr_wdata[MIX_W-1:0];
               CSR_GAIN:    cfg.gain      = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_q.insert(expected_q.size(),
                              swell_sample(req_tdata[SAMPLE_BITS-1:0],
                                           req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
         results_outstanding <= expected_q.size();
      end
   end

endmodule

[dv/tb_auto_swell_envelope_gain.sv]
// ----------------------------------------------------------------------------
// tb_auto_swell_envelope_gain
// Drives stereo pairs and register settings into the swell block: a directed
// pass over full-scale samples and register extremes, then phases of random
// settings with note-shaped bursts and noise, under random idle and stall
// bursts on both streams, bar the last phase. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_auto_swell_envelope_gain;
   import asg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h800000;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG1 = 24'hFFFFFF;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [47:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    mismatch_total;
   int                    pending_results;
   logic                  steady_tail = 1'b0;
   int unsigned           stall_left = 0;

   auto_swell_envelope_gain dut (.*);

   auto_swell_envelope_gain_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_addr, .csr_wdata,
      .mismatch_count(mismatch_total), .results_outstanding(pending_results)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!steady_tail && $urandom_range(7) == 0) begin
         stall_left <= $urandom_range(15, 1) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
      req_tvalid <= 1'b1;
      req_tdata  <= {r, l};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!steady_tail && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(posedge clock);
      end
   endtask

   // hold until every result is out and the pipeline is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [23:0] attack, input logic [23:0] rel,
                                input logic [23:0] rate, input logic [THR_W-1:0] thr,
                                input logic [MIX_W-1:0] mix, input logic [GAIN_W-1:0] gain);
      write_reg(CSR_ATTACK, attack);
      write_reg(CSR_RELEASE, rel);
      write_reg(CSR_RATE, rate);
      write_reg(CSR_THRESH, {1'($urandom), thr});
      write_reg(CSR_MIX, {7'($urandom), mix});
      write_reg(CSR_GAIN, {10'($urandom), gain});
      write_reg($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, 24'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] rand_sample(int unsigned mag_max);
      logic [SAMPLE_BITS-1:0] m;
      m = SAMPLE_BITS'($urandom_range(mag_max));
      return ($urandom_range(1) == 1) ? -m : m;
   endfunction

   task automatic pick_settings();
      logic [23:0]       attack;
      logic [23:0]       rel;
      logic [23:0]       rate;
      logic [THR_W-1:0]  thr;
      logic [MIX_W-1:0]  mix;
      logic [GAIN_W-1:0] gain;
      case ($urandom_range(7))
         0: attack = '0;
         1: attack = '1;
         2: attack = 24'($urandom);
         default: attack = 24'($urandom_range(24'hFFFFFF, 24'hC00000));
      endcase
      case ($urandom_range(7))
         0: rel = '0;
         1: rel = '1;
         2: rel = 24'($urandom);
         default: rel = 24'($urandom_range(24'hE00000, 24'h400000));
      endcase
      case ($urandom_range(7))
         0: rate = '0;
         1: rate = '1;
         2: rate = 24'($urandom);
         default: rate = 24'($urandom_range(24'h00FFFF));
      endcase
      case ($urandom_range(7))
         0: thr = '0;
         1: thr = '1;
         2: thr = THR_W'($urandom);
         default: thr = THR_W'($urandom_range(23'h400000, 23'h001000));
      endcase
      case ($urandom_range(7))
         0: mix = '0;
         1: mix = MIX_FULL;
         2: mix = '1;
         3: mix = MIX_W'($urandom);
         default: mix = MIX_W'($urandom_range(MIX_FULL));
      endcase
      case ($urandom_range(7))
         0: gain = '0;
         1: gain = '1;
         2: gain = GAIN_W'($urandom);
         default: gain = GAIN_W'($urandom_range(8192));
      endcase
      load_settings(attack, rel, rate, thr, mix, gain);
   endtask

   // notes: a quiet stretch, then a loud burst; a share of plain noise
   task automatic run_phase(input int count);
      int unsigned            sent;
      int unsigned            quiet_len;
      int unsigned            loud_len;
      int unsigned            amp;
      logic [SAMPLE_BITS-1:0] l;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(3) == 0) begin
            send_pair(24'($urandom), 24'($urandom));
            sent++;
         end else begin
            quiet_len = $urandom_range(60, 10);
            loud_len  = $urandom_range(20, 2);
            amp       = $urandom_range(24'h7FFFFF, 24'h100000);
            repeat (quiet_len) begin
               l = rand_sample(255);
               send_pair(l, $urandom_range(1) ? l : rand_sample(255));
               sent++;
            end
            repeat (loud_len) begin
               l = rand_sample(amp);
               send_pair(l, $urandom_range(1) ? l : 24'($urandom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair('0, '0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(SAMPLE_NEG1, 24'd1);
      send_pair(24'd1, SAMPLE_NEG1);
      settle();

      load_settings('0, '0, '0, 23'h400000, '1, '1);
      send_pair('0, '0);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair('0, 24'h123456);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      settle();

      load_settings('1, '1, '1, '0, '0, '0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      settle();

      load_settings(24'hC00000, 24'h800000, 24'h001000, '1, '0, '1);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(SAMPLE_NEG1, 24'd1);
      settle();

      repeat (7) begin
         pick_settings();
         run_phase(125);
         settle();
      end

      steady_tail <= 1'b1;
      pick_settings();
      run_phase(125);
      settle();

      if (mismatch_total == 0 && pending_results == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/asg_pkg.sv
hw/rtl/asg_csr.sv
hw/rtl/asg_mul.sv
hw/rtl/asg_seq.sv
hw/rtl/auto_swell_envelope_gain.sv
dv/auto_swell_envelope_gain_checker.sv
dv/tb_auto_swell_envelope_gain.sv
